### hw/rtl/rmst_pkg.sv
package rmst_pkg;

   localparam int VALUE_W = 31;
   localparam int POS_W   = 11;
   localparam int CFG_W   = 11;
   localparam int CSR_AW  = 3;
   localparam int CSR_DW  = 32;

   localparam logic signed [VALUE_W-1:0] SENTINEL = -31'sd1000000000;
   localparam logic signed [VALUE_W-1:0] VAL_MAX  = 31'sd1000000000;

   localparam logic [CFG_W-1:0] ENTRIES_RESET = 11'd1024;

   // register index taken from the word address bit
   localparam logic REG_ENTRIES = 1'b0;

   localparam logic ACT_UPDATE = 1'b0;
   localparam logic ACT_QUERY  = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPD_LEAF,
      ST_UPD_MERGE,
      ST_QRY_START,
      ST_QRY_B,
      ST_QRY_SA,
      ST_QRY_OUT
   } seq_state_type;

endpackage

### hw/rtl/rmst_max.sv
module rmst_max (
   input  logic signed [rmst_pkg::VALUE_W-1:0] op_a,
   input  logic signed [rmst_pkg::VALUE_W-1:0] op_b,
   output logic signed [rmst_pkg::VALUE_W-1:0] op_max
);

   assign op_max = (op_a > op_b) ? op_a : op_b;

endmodule

### hw/rtl/rmst_mem.sv
module rmst_mem #(
   parameter int AW = 11
) (
   input  logic                               clock,
   input  logic                               wr_en,
   input  logic [AW-1:0]                      wr_addr,
   input  logic signed [rmst_pkg::VALUE_W-1:0] wr_data,
   input  logic [AW-1:0]                      rd_addr,
   output logic signed [rmst_pkg::VALUE_W-1:0] rd_data
);

   logic signed [rmst_pkg::VALUE_W-1:0] mem_ff [2**AW];
   logic signed [rmst_pkg::VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/rmst_csr.sv
module rmst_csr #(
   parameter int LEAVES = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [rmst_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [rmst_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [rmst_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                          csr_pready,
   output logic [$clog2(LEAVES):0]       tree_size,
   output logic                          cfg_clear
);

   localparam int LW = $clog2(LEAVES);
   localparam int SW = LW + 1;
   localparam int EW = (rmst_pkg::CFG_W > SW) ? rmst_pkg::CFG_W : SW;

   logic [rmst_pkg::CFG_W-1:0] entries_ff, entries_in;
   logic [SW-1:0]              size_ff, size_in;
   logic                       reg_idx;
   logic                       wr_hit;

   function automatic logic [SW-1:0] tree_size_of(input logic [rmst_pkg::CFG_W-1:0] n);
      logic [EW-1:0] want;
      logic [SW-1:0] s;
      logic          found;
      want  = (EW'(n) > EW'(LEAVES)) ? EW'(LEAVES) : EW'(n);
      s     = SW'(LEAVES);
      found = 1'b0;
      for (int i = 0; i <= LW; i++) begin
         if (!found && ((EW'(1) << i) >= want)) begin
            s     = SW'(1) << i;
            found = 1'b1;
         end
      end
      return s;
   endfunction

   assign reg_idx    = csr_paddr[rmst_pkg::CSR_AW-1];
   assign csr_pready = 1'b1;
   assign wr_hit     = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (reg_idx == rmst_pkg::REG_ENTRIES);
   assign cfg_clear  = wr_hit;
   assign tree_size  = size_ff;

   always_comb begin
      entries_in = entries_ff;
      size_in    = size_ff;
      if (wr_hit) begin
         entries_in = csr_pwdata[rmst_pkg::CFG_W-1:0];
         size_in    = tree_size_of(csr_pwdata[rmst_pkg::CFG_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entries_ff <= rmst_pkg::ENTRIES_RESET;
         size_ff    <= tree_size_of(rmst_pkg::ENTRIES_RESET);
      end else begin
         entries_ff <= entries_in;
         size_ff    <= size_in;
      end
   end

   assign csr_prdata = (reg_idx == rmst_pkg::REG_ENTRIES)
                       ? rmst_pkg::CSR_DW'(entries_ff) : '0;

endmodule

### hw/rtl/rmst_seq.sv
module rmst_seq #(
   parameter int LEAVES = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [$clog2(LEAVES):0]             tree_size,
   input  logic                                cfg_clear,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_action,
   input  logic [rmst_pkg::POS_W-1:0]          req_position,
   input  logic [rmst_pkg::POS_W-1:0]          req_range_end,
   input  logic signed [rmst_pkg::VALUE_W-1:0] req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [rmst_pkg::VALUE_W-1:0] rsp_max_value,
   output logic                                rsp_is_empty
);

   localparam int LW = $clog2(LEAVES);
   localparam int NW = LW + 1;
   localparam int AW = LW + 2;
   localparam int XW = (AW > rmst_pkg::POS_W) ? AW : rmst_pkg::POS_W;

   rmst_pkg::seq_state_type state_ff, state_in;

   logic [NW-1:0]                       node_ff, node_in;
   logic [NW-1:0]                       clr_cnt_ff, clr_cnt_in;
   logic [AW-1:0]                       a_ff, a_in, b_ff, b_in;
   logic signed [rmst_pkg::VALUE_W-1:0] cur_ff, cur_in, best_ff, best_in;
   logic                                pend_ff, pend_in;
   logic                                empty_ff, empty_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic signed [rmst_pkg::VALUE_W-1:0] rsp_max_value_ff, rsp_max_value_in;
   logic                                rsp_is_empty_ff, rsp_is_empty_in;

   logic                                accept, out_free;
   logic [XW-1:0]                       pos_x, end_x, size_x, lo_x, hi_x;
   logic                                upd_ok, q_empty;
   logic [NW-1:0]                       leaf, parent;
   logic [AW-1:0]                       a_start, b_start, na, nb;
   logic signed [rmst_pkg::VALUE_W-1:0] v_sat;

   logic                                mem_we;
   logic [NW-1:0]                       mem_waddr, mem_raddr;
   logic signed [rmst_pkg::VALUE_W-1:0] mem_wdata, mem_rdata;
   logic signed [rmst_pkg::VALUE_W-1:0] op_a, op_max;

   rmst_mem #(.AW(NW)) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   rmst_max u_max (
      .op_a   (op_a),
      .op_b   (mem_rdata),
      .op_max (op_max)
   );

   assign req_stall = (state_ff != rmst_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign pos_x   = XW'(req_position);
   assign end_x   = XW'(req_range_end);
   assign size_x  = XW'(tree_size);
   assign upd_ok  = (pos_x != '0) && (pos_x <= size_x);
   assign leaf    = NW'(pos_x + size_x - XW'(1));
   assign lo_x    = (pos_x == '0) ? XW'(1) : pos_x;
   assign hi_x    = (end_x > size_x + XW'(1)) ? size_x + XW'(1) : end_x;
   assign q_empty = (lo_x >= hi_x);
   assign a_start = AW'(lo_x + size_x - XW'(1));
   assign b_start = AW'(hi_x + size_x - XW'(1));
   assign v_sat   = (req_value > rmst_pkg::VAL_MAX)  ? rmst_pkg::VAL_MAX :
                    (req_value < rmst_pkg::SENTINEL) ? rmst_pkg::SENTINEL : req_value;

   assign parent = node_ff >> 1;
   assign na     = a_ff >> 1;
   assign nb     = b_ff >> 1;
   assign op_a   = (state_ff == rmst_pkg::ST_UPD_MERGE) ? cur_ff : best_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rmst_pkg::ST_CLEAR: begin
            if (&clr_cnt_ff) state_in = rmst_pkg::ST_IDLE;
         end
         rmst_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_action == rmst_pkg::ACT_UPDATE) begin
                  state_in = upd_ok ? rmst_pkg::ST_UPD_LEAF : rmst_pkg::ST_IDLE;
               end else begin
                  state_in = q_empty ? rmst_pkg::ST_QRY_OUT : rmst_pkg::ST_QRY_START;
               end
            end
         end
         rmst_pkg::ST_UPD_LEAF: begin
            state_in = (node_ff == NW'(1)) ? rmst_pkg::ST_IDLE : rmst_pkg::ST_UPD_MERGE;
         end
         rmst_pkg::ST_UPD_MERGE: begin
            if (parent == NW'(1)) state_in = rmst_pkg::ST_IDLE;
         end
         rmst_pkg::ST_QRY_START: state_in = rmst_pkg::ST_QRY_B;
         rmst_pkg::ST_QRY_B:     state_in = rmst_pkg::ST_QRY_SA;
         rmst_pkg::ST_QRY_SA: begin
            state_in = (na >= nb) ? rmst_pkg::ST_QRY_OUT : rmst_pkg::ST_QRY_B;
         end
         rmst_pkg::ST_QRY_OUT: begin
            if (out_free) state_in = rmst_pkg::ST_IDLE;
         end
         default: state_in = rmst_pkg::ST_IDLE;
      endcase
      if (cfg_clear) state_in = rmst_pkg::ST_CLEAR;
   end

   // datapath and memory control
   always_comb begin
      node_in          = node_ff;
      clr_cnt_in       = clr_cnt_ff;
      a_in             = a_ff;
      b_in             = b_ff;
      cur_in           = cur_ff;
      best_in          = best_ff;
      pend_in          = pend_ff;
      empty_in         = empty_ff;
      rsp_max_value_in = rsp_max_value_ff;
      rsp_is_empty_in  = rsp_is_empty_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      mem_we           = 1'b0;
      mem_waddr        = node_ff;
      mem_wdata        = cur_ff;
      mem_raddr        = node_ff;
      case (state_ff)
         rmst_pkg::ST_CLEAR: begin
            mem_we     = 1'b1;
            mem_waddr  = clr_cnt_ff;
            mem_wdata  = '0;
            clr_cnt_in = clr_cnt_ff + NW'(1);
         end
         rmst_pkg::ST_IDLE: begin
            if (accept) begin
               node_in  = leaf;
               cur_in   = v_sat;
               a_in     = a_start;
               b_in     = b_start;
               best_in  = rmst_pkg::SENTINEL;
               empty_in = q_empty;
               pend_in  = 1'b0;
            end
         end
         rmst_pkg::ST_UPD_LEAF: begin
            mem_we    = 1'b1;
            mem_waddr = node_ff;
            mem_wdata = cur_ff;
            mem_raddr = node_ff ^ NW'(1);
         end
         rmst_pkg::ST_UPD_MERGE: begin
            mem_we    = 1'b1;
            mem_waddr = parent;
            mem_wdata = op_max;
            mem_raddr = parent ^ NW'(1);
            cur_in    = op_max;
            node_in   = parent;
         end
         rmst_pkg::ST_QRY_START: begin
            mem_raddr = NW'(a_ff);
            pend_in   = a_ff[0];
            if (a_ff[0]) a_in = a_ff + AW'(1);
         end
         rmst_pkg::ST_QRY_B: begin
            if (pend_ff) best_in = op_max;
            mem_raddr = NW'(b_ff - AW'(1));
            pend_in   = b_ff[0];
            if (b_ff[0]) b_in = b_ff - AW'(1);
         end
         rmst_pkg::ST_QRY_SA: begin
            if (pend_ff) best_in = op_max;
            mem_raddr = NW'(na);
            pend_in   = na[0];
            a_in      = na[0] ? na + AW'(1) : na;
            b_in      = nb;
         end
         rmst_pkg::ST_QRY_OUT: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_max_value_in = best_ff;
               rsp_is_empty_in  = empty_ff;
            end
         end
         default: begin
         end
      endcase
      if (cfg_clear) clr_cnt_in = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rmst_pkg::ST_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      node_ff          <= node_in;
      a_ff             <= a_in;
      b_ff             <= b_in;
      cur_ff           <= cur_in;
      best_ff          <= best_in;
      pend_ff          <= pend_in;
      empty_ff         <= empty_in;
      rsp_max_value_ff <= rsp_max_value_in;
      rsp_is_empty_ff  <= rsp_is_empty_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_max_value = rsp_max_value_ff;
   assign rsp_is_empty  = rsp_is_empty_ff;

   a_merge_not_root: assert property (@(posedge clock) disable iff (reset)
      state_ff == rmst_pkg::ST_UPD_MERGE |-> node_ff >= NW'(2))
      else $error("merge step reached with node at root");

   a_walk_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == rmst_pkg::ST_QRY_B |-> a_ff <= b_ff)
      else $error("query walk bounds crossed");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == rmst_pkg::ST_QRY_OUT))
      else $error("result loaded outside query output step");

   a_empty_sentinel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_is_empty_ff |-> rsp_max_value_ff == rmst_pkg::SENTINEL)
      else $error("empty result without sentinel value");

endmodule

### hw/rtl/range_max_segment_tree_top.sv
// channel  direction  handshake                 payload
// req      in         req_valid / req_stall     action, position, range_end, value
// rsp      out        rsp_valid / rsp_stall     max_value, is_empty
// csr      in         csr_psel/penable/pready   entries_in_use at byte address 0
//
// update: one leaf write then one parent write per level
// query: walks up level by level, ST_QRY_B then ST_QRY_SA, through the one read port
// reset and each entries_in_use write start a clear sweep of all 2*LEAVES memory words, req stalled
// one item at a time; the next item is taken while a result still waits on rsp_stall
// LEAVES must be a power of two
module range_max_segment_tree_top #(
   parameter int LEAVES = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_action,
   input  logic [rmst_pkg::POS_W-1:0]          req_position,
   input  logic [rmst_pkg::POS_W-1:0]          req_range_end,
   input  logic signed [rmst_pkg::VALUE_W-1:0] req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [rmst_pkg::VALUE_W-1:0] rsp_max_value,
   output logic                                rsp_is_empty,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [rmst_pkg::CSR_AW-1:0]         csr_paddr,
   input  logic [rmst_pkg::CSR_DW-1:0]         csr_pwdata,
   output logic [rmst_pkg::CSR_DW-1:0]         csr_prdata,
   output logic                                csr_pready
);

   logic [$clog2(LEAVES):0] tree_size;
   logic                    cfg_clear;

   rmst_csr #(.LEAVES(LEAVES)) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .tree_size   (tree_size),
      .cfg_clear   (cfg_clear)
   );

   rmst_seq #(.LEAVES(LEAVES)) u_seq (
      .clock         (clock),
      .reset         (reset),
      .tree_size     (tree_size),
      .cfg_clear     (cfg_clear),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_action    (req_action),
      .req_position  (req_position),
      .req_range_end (req_range_end),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_max_value (rsp_max_value),
      .rsp_is_empty  (rsp_is_empty)
   );

endmodule
